>>> hw/rtl/tpbc_pkg.sv
// Shared types, widths and codes for the tagged pointer bounds checker.
// Used by tpbc_ctrl, tpbc_dp and the top level; depends on nothing.
`timescale 1ns / 1ps

package tpbc_pkg;

	// table geometry
	localparam int TAG_BITS  = 16;
	localparam int SIZE_BITS = 32;
	localparam int TAG_DEPTH = 1 << TAG_BITS;
	localparam int NT_W      = TAG_BITS + 1;

	// fixed field widths
	localparam int PTR_W    = 64;
	localparam int ADDR_W   = 48;
	localparam int TAG_W    = 16;
	localparam int SIZE_W   = 32;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 3;
	// bound sums: address plus size never exceeds two more bits
	localparam int SUM_W    = ADDR_W + 2;

	// operations
	localparam logic [FUNC_W-1:0] F_ALLOC   = 2'd0;
	localparam logic [FUNC_W-1:0] F_REALLOC = 2'd1;
	localparam logic [FUNC_W-1:0] F_FREE    = 2'd2;
	localparam logic [FUNC_W-1:0] F_CHECK   = 2'd3;

	// result codes
	localparam logic [STATUS_W-1:0] R_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] R_UNTRACKED = 3'd1;
	localparam logic [STATUS_W-1:0] R_OVERFLOW  = 3'd2;
	localparam logic [STATUS_W-1:0] R_UAF       = 3'd3;
	localparam logic [STATUS_W-1:0] R_DOUBLE    = 3'd4;
	localparam logic [STATUS_W-1:0] R_UNKNOWN   = 3'd5;
	localparam logic [STATUS_W-1:0] R_EXHAUSTED = 3'd6;

	// controller to datapath commands
	typedef struct packed {
		logic capture;  // input beat accepted, table read issued
		logic calc;     // table data back: sums, retire old entry
		logic finish;   // compare, allocate, load output register
	} cmd_t;

endpackage

>>> hw/rtl/tpbc_ctrl.sv
// Sequencing state machine and output valid for the bounds checker.
// Depends on tpbc_pkg (cmd_t); drives tpbc_dp through the command struct.
`timescale 1ns / 1ps

module tpbc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output tpbc_pkg::cmd_t   cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_CALC   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	assign cmd.capture = in_ready && in_valid;
	assign cmd.calc    = (state_q == S_CALC);
	assign cmd.finish  = (state_q == S_FINISH) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_CALC;
			end
			S_CALC: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				// hold here while the previous result is still unread
				if (out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.calc, cmd.finish}))
		else $error("more than one datapath command at once");

	a_capture_then_calc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.calc)
		else $error("table read not followed by calc step");

	a_calc_then_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.calc |=> (state_q == S_FINISH))
		else $error("calc step not followed by finish");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("result appeared without a finish step");
`endif

endmodule

>>> hw/rtl/tpbc_dp.sv
// Datapath: object table memories, tag counter, bound arithmetic, output register.
// Depends on tpbc_pkg; sequenced by tpbc_ctrl through tpbc_pkg::cmd_t.
`timescale 1ns / 1ps

module tpbc_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tpbc_pkg::cmd_t                      cmd,
	input  logic [tpbc_pkg::FUNC_W-1:0]         func,
	input  logic [tpbc_pkg::PTR_W-1:0]          pointer,
	input  logic [tpbc_pkg::ADDR_W-1:0]         new_base,
	input  logic [tpbc_pkg::SIZE_W-1:0]         size,
	output logic [tpbc_pkg::STATUS_W-1:0]       status,
	output logic [tpbc_pkg::PTR_W-1:0]          result_pointer,
	output logic [tpbc_pkg::ADDR_W-1:0]         plain_address,
	output logic [tpbc_pkg::TAG_W-1:0]          tag,
	output logic [tpbc_pkg::ADDR_W-1:0]         object_base,
	output logic [tpbc_pkg::SIZE_W-1:0]         object_size
);

	// object table; the freed flag stands in for active/freed, and any tag at or
	// above next_tag_q has never been written and counts as unused
	logic [tpbc_pkg::ADDR_W-1:0]    base_mem  [tpbc_pkg::TAG_DEPTH];
	logic [tpbc_pkg::SIZE_BITS-1:0] size_mem  [tpbc_pkg::TAG_DEPTH];
	logic                           freed_mem [tpbc_pkg::TAG_DEPTH];

	logic [tpbc_pkg::NT_W-1:0]      next_tag_q;

	logic [tpbc_pkg::FUNC_W-1:0]    func_q;
	logic [tpbc_pkg::TAG_W-1:0]     ptag_q;
	logic [tpbc_pkg::ADDR_W-1:0]    addr_q;
	logic [tpbc_pkg::ADDR_W-1:0]    nb_q;
	logic [tpbc_pkg::SIZE_W-1:0]    sz_q;
	logic [tpbc_pkg::ADDR_W-1:0]    rd_base_q;
	logic [tpbc_pkg::SIZE_BITS-1:0] rd_size_q;
	logic                           rd_freed_q;

	logic [tpbc_pkg::SUM_W-1:0]     obj_end_q;
	logic [tpbc_pkg::SUM_W-1:0]     acc_end_q;
	logic                           below_q;

	logic [tpbc_pkg::STATUS_W-1:0]  status_q;
	logic [tpbc_pkg::PTR_W-1:0]     rptr_q;
	logic [tpbc_pkg::ADDR_W-1:0]    paddr_q;
	logic [tpbc_pkg::TAG_W-1:0]     tag_q;
	logic [tpbc_pkg::ADDR_W-1:0]    obase_q;
	logic [tpbc_pkg::SIZE_W-1:0]    osize_q;

	logic [tpbc_pkg::TAG_W-1:0]     ptag_in;
	logic [tpbc_pkg::TAG_BITS-1:0]  rd_idx;
	logic [tpbc_pkg::TAG_BITS-1:0]  old_idx;
	logic [tpbc_pkg::TAG_BITS-1:0]  new_idx;
	logic                           is_alloc;
	logic                           alloc_fail;
	logic                           exhausted;
	logic                           alloc_go;
	logic                           written;
	logic                           retire;

	logic [tpbc_pkg::STATUS_W-1:0]  status_d;
	logic [tpbc_pkg::PTR_W-1:0]     rptr_d;
	logic [tpbc_pkg::TAG_W-1:0]     tag_d;
	logic [tpbc_pkg::ADDR_W-1:0]    obase_d;
	logic [tpbc_pkg::SIZE_W-1:0]    osize_d;

	assign ptag_in = pointer[tpbc_pkg::PTR_W-1:tpbc_pkg::ADDR_W];
	assign rd_idx  = ptag_in[tpbc_pkg::TAG_BITS-1:0];
	assign old_idx = ptag_q[tpbc_pkg::TAG_BITS-1:0];
	assign new_idx = next_tag_q[tpbc_pkg::TAG_BITS-1:0];

	assign is_alloc   = (func_q == tpbc_pkg::F_ALLOC) || (func_q == tpbc_pkg::F_REALLOC);
	assign alloc_fail = (nb_q == '0);
	assign exhausted  = next_tag_q[tpbc_pkg::TAG_BITS];
	assign alloc_go   = is_alloc && !alloc_fail && !exhausted;
	// below next_tag means in range and written at some point
	assign written    = (ptag_q != '0) &&
		((tpbc_pkg::TAG_W + 1)'(ptag_q) < (tpbc_pkg::TAG_W + 1)'(next_tag_q));

	// active entry that a free or a successful reallocate moves to freed
	assign retire = written && !rd_freed_q &&
		((func_q == tpbc_pkg::F_FREE) ||
		 ((func_q == tpbc_pkg::F_REALLOC) && !alloc_fail && !exhausted));

	// input capture and table read
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q     <= func;
			ptag_q     <= ptag_in;
			addr_q     <= pointer[tpbc_pkg::ADDR_W-1:0];
			nb_q       <= new_base;
			sz_q       <= size;
			rd_base_q  <= base_mem[rd_idx];
			rd_size_q  <= size_mem[rd_idx];
			rd_freed_q <= freed_mem[rd_idx];
		end
	end

	// table writes: retire in calc, new entry in finish
	always_ff @(posedge clk) begin
		if (cmd.calc && retire) begin
			freed_mem[old_idx] <= 1'b1;
		end else if (cmd.finish && alloc_go) begin
			freed_mem[new_idx] <= 1'b0;
		end
		if (cmd.finish && alloc_go) begin
			base_mem[new_idx] <= nb_q;
			size_mem[new_idx] <= tpbc_pkg::SIZE_BITS'(sz_q);
		end
	end

	// bound sums, compared in the finish step
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			obj_end_q <= tpbc_pkg::SUM_W'(rd_base_q) + tpbc_pkg::SUM_W'(rd_size_q);
			acc_end_q <= tpbc_pkg::SUM_W'(addr_q) + tpbc_pkg::SUM_W'(sz_q);
			below_q   <= addr_q < rd_base_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_tag_q <= tpbc_pkg::NT_W'(1);
		end else if (cmd.finish && alloc_go) begin
			next_tag_q <= next_tag_q + tpbc_pkg::NT_W'(1);
		end
	end

	always_comb begin
		status_d = tpbc_pkg::R_OK;
		rptr_d   = '0;
		tag_d    = '0;
		obase_d  = '0;
		osize_d  = '0;
		if (is_alloc) begin
			if (alloc_fail) begin
				status_d = tpbc_pkg::R_OK;
			end else if (exhausted) begin
				status_d = tpbc_pkg::R_EXHAUSTED;
			end else begin
				tag_d   = tpbc_pkg::TAG_W'(next_tag_q);
				rptr_d  = {tag_d, nb_q};
				obase_d = nb_q;
				osize_d = tpbc_pkg::SIZE_W'(tpbc_pkg::SIZE_BITS'(sz_q));
			end
		end else if (ptag_q == '0) begin
			status_d = tpbc_pkg::R_UNTRACKED;
		end else if (!written) begin
			status_d = tpbc_pkg::R_UNKNOWN;
			tag_d    = ptag_q;
		end else begin
			tag_d   = ptag_q;
			obase_d = rd_base_q;
			osize_d = tpbc_pkg::SIZE_W'(rd_size_q);
			if (func_q == tpbc_pkg::F_FREE)
				status_d = rd_freed_q ? tpbc_pkg::R_DOUBLE : tpbc_pkg::R_OK;
			else if (rd_freed_q)
				status_d = tpbc_pkg::R_UAF;
			else if (below_q || (acc_end_q > obj_end_q))
				status_d = tpbc_pkg::R_OVERFLOW;
			else
				status_d = tpbc_pkg::R_OK;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q <= status_d;
			rptr_q   <= rptr_d;
			paddr_q  <= addr_q;
			tag_q    <= tag_d;
			obase_q  <= obase_d;
			osize_q  <= osize_d;
		end
	end

	assign status         = status_q;
	assign result_pointer = rptr_q;
	assign plain_address  = paddr_q;
	assign tag            = tag_q;
	assign object_base    = obase_q;
	assign object_size    = osize_q;

endmodule

>>> hw/rtl/tagged_pointer_bounds_checker.sv
// Tagged pointer heap bounds checker: top level.
// Instantiates tpbc_ctrl and tpbc_dp; widths and codes from tpbc_pkg.
//
// Input channel (in_valid/in_ready): one beat is one operation: func selects
// allocate, reallocate, free or access check; pointer carries the tag in its
// top 16 bits. Output channel (out_valid/out_ready): one result beat per input
// beat, in order.
// Each item runs through the capture, calc and finish steps: the accept cycle
// issues the object table read, the next cycle forms the two bound sums from
// the registered table data (and retires the old entry), and the finish step
// compares, allocates and loads the output register. A new item is accepted
// only once the previous one has left the finish step.
// in_ready is high whenever the sequencer is idle, even while a result waits.
// If out_ready stays low, the next item runs up to its final step and waits
// there until the output register frees.
// Reset sets the next tag to one and drops out_valid. The table is not swept:
// tags are handed out in order, so any tag at or above the next tag reads as
// unused.
`timescale 1ns / 1ps

module tagged_pointer_bounds_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [tpbc_pkg::FUNC_W-1:0]         func,
	input  logic [tpbc_pkg::PTR_W-1:0]          pointer,
	input  logic [tpbc_pkg::ADDR_W-1:0]         new_base,
	input  logic [tpbc_pkg::SIZE_W-1:0]         size,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tpbc_pkg::STATUS_W-1:0]       status,
	output logic [tpbc_pkg::PTR_W-1:0]          result_pointer,
	output logic [tpbc_pkg::ADDR_W-1:0]         plain_address,
	output logic [tpbc_pkg::TAG_W-1:0]          tag,
	output logic [tpbc_pkg::ADDR_W-1:0]         object_base,
	output logic [tpbc_pkg::SIZE_W-1:0]         object_size
);

	tpbc_pkg::cmd_t cmd;

	tpbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	tpbc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.func           (func),
		.pointer        (pointer),
		.new_base       (new_base),
		.size           (size),
		.status         (status),
		.result_pointer (result_pointer),
		.plain_address  (plain_address),
		.tag            (tag),
		.object_base    (object_base),
		.object_size    (object_size)
	);

endmodule
